[rtl/core/kiat_pkg.sv]
// ----------------------------------------------------------------------------
// kiat_pkg
// Operation codes and sequencer states of the keyed interval attribute table.
// ----------------------------------------------------------------------------
package kiat_pkg;

  localparam int unsigned FieldBits = 32;
  localparam int unsigned KeyBits   = 3;

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_LOOKUP     = 3'd2,
    OP_SHIFT_INS  = 3'd3,
    OP_SHIFT_DEL  = 3'd4,
    OP_MERGE      = 3'd5,
    OP_CLEAR_KEY  = 3'd6,
    OP_CLEAR_ALL  = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_SPLIT,
    S_CHECK,
    S_STORE,
    S_MDEC,
    S_MWB,
    S_DONE
  } state_e;

endpackage

[rtl/core/kiat_if.sv]
// ----------------------------------------------------------------------------
// kiat_in_if / kiat_out_if
// Valid/ready channels carrying operation beats in and result beats out.
// ----------------------------------------------------------------------------
interface kiat_in_if import kiat_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           operation;
  logic [KeyBits-1:0]   key;
  logic [FieldBits-1:0] range_start;
  logic [FieldBits-1:0] range_end;
  logic [FieldBits-1:0] position;
  logic [FieldBits-1:0] length;
  logic [FieldBits-1:0] value;

  modport source (output valid, operation, key, range_start, range_end, position,
                  length, value, input ready);
  modport sink (input valid, operation, key, range_start, range_end, position,
                length, value, output ready);
endinterface

interface kiat_out_if import kiat_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [FieldBits-1:0] found_value;
  logic                 status;

  modport source (output valid, found, found_value, status, input ready);
  modport sink (input valid, found, found_value, status, output ready);
endinterface

[rtl/core/keyed_interval_attribute_table_top.sv]
// ----------------------------------------------------------------------------
// keyed_interval_attribute_table_top
// Keyed table of half-open intervals held in a single-port slot memory.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  in_i      sink       operation, key, range_start, range_end, position,
//                       length, value
//  out_o     source     found, found_value, status (one beat per operation)
//
// Every slot walk reads each slot, then evaluates and writes it, on the
// one memory port. Add and remove walk twice (count, then cut), with a
// split step for each interval cut in two. Merge walks once per sorted
// candidate. Clear all and ignored operations go straight to the result.
// Slot valid bits reset at once; no clearing pass. A stalled result holds
// the sequencer in its final state, and a new beat is taken only when it
// is idle.
module keyed_interval_attribute_table_top import kiat_pkg::*; #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned KEY_COUNT   = 8,
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  kiat_in_if.sink    in_i,
  kiat_out_if.source out_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned OB = OFFSET_BITS;
  localparam int unsigned VB = VALUE_BITS;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [OB-1:0]      s;
    logic [OB-1:0]      e;
    logic [VB-1:0]      v;
  } rec_t;

  rec_t mem [SLOTS];
  rec_t rdata_q;
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  rec_t          mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  state_e state_q, state_d;
  logic [SLOTS-1:0] valid_q, valid_d, seen_q, seen_d;
  op_e              op_q, op_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic [OB-1:0] rs_q, rs_d, re_q, re_d, pos_q, pos_d, len_q, len_d;
  logic [VB-1:0] val_q, val_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          pass_q, pass_d;
  logic [CW-1:0] nsplit_q, nsplit_d, nfree_q, nfree_d;
  logic          cand_q, cand_d, have_w_q, have_w_d;
  logic [IW-1:0] cand_idx_q, cand_idx_d, w_idx_q, w_idx_d;
  logic [OB-1:0] cand_s_q, cand_s_d, cand_e_q, cand_e_d;
  logic [OB-1:0] w_s_q, w_s_d, w_e_q, w_e_d;
  logic [VB-1:0] cand_v_q, cand_v_d, w_v_q, w_v_d;
  logic [OB-1:0] sp_e_q, sp_e_d;
  logic [VB-1:0] sp_v_q, sp_v_d;
  logic          res_found_q, res_found_d, res_status_q, res_status_d;
  logic [VB-1:0] res_val_q, res_val_d;
  logic          out_valid_q, out_valid_d;
  logic          out_found_q, out_status_q;
  logic [VB-1:0] out_val_q;

  logic [IW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end

  function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a,
                                            input logic [OB-1:0] b);
    logic [OB:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[OB] ? '1 : sum[OB-1:0];
  endfunction

  logic          accept, last, v_cur, match, hit, key_ok;
  logic [OB-1:0] in_rs, in_re, dlen;
  logic [CW:0]   need;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_rs    = OB'(in_i.range_start);
  assign in_re    = OB'(in_i.range_end);
  assign key_ok   = 32'(in_i.key) < KEY_COUNT;
  assign last     = (idx_q == IW'(SLOTS - 1));
  assign v_cur    = valid_q[idx_q];
  assign match    = v_cur && (rdata_q.key == key_q);
  assign hit      = match && (rdata_q.s < re_q) && (rdata_q.e > rs_q);
  assign dlen     = re_q - rs_q;
  assign need     = {1'b0, nsplit_q} + ((op_q == OP_ADD) ? (CW + 1)'(1) : '0);

  always_comb begin
    logic adv;
    state_d = state_q;   valid_d = valid_q;   seen_d = seen_q;
    op_d = op_q;         key_d = key_q;       rs_d = rs_q;   re_d = re_q;
    pos_d = pos_q;       len_d = len_q;       val_d = val_q; idx_d = idx_q;
    pass_d = pass_q;     nsplit_d = nsplit_q; nfree_d = nfree_q;
    cand_d = cand_q;     cand_idx_d = cand_idx_q; cand_s_d = cand_s_q;
    cand_e_d = cand_e_q; cand_v_d = cand_v_q; have_w_d = have_w_q;
    w_idx_d = w_idx_q;   w_s_d = w_s_q;       w_e_d = w_e_q; w_v_d = w_v_q;
    sp_e_d = sp_e_q;     sp_v_d = sp_v_q;
    res_found_d = res_found_q; res_val_d = res_val_q; res_status_d = res_status_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_we = 1'b0;  mem_addr = idx_q;  mem_wdata = rdata_q;
    adv = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = op_e'(in_i.operation);  key_d = in_i.key;
          rs_d = in_rs;  re_d = in_re;  pos_d = OB'(in_i.position);
          len_d = OB'(in_i.length);  val_d = VB'(in_i.value);
          idx_d = '0;  pass_d = 1'b0;  nsplit_d = '0;  nfree_d = '0;
          cand_d = 1'b0;  have_w_d = 1'b0;  seen_d = '0;
          res_found_d = 1'b0;  res_val_d = '0;  res_status_d = 1'b0;
          state_d = S_RD;
          case (op_e'(in_i.operation))
            OP_ADD, OP_REMOVE: if (in_re < in_rs || !key_ok) state_d = S_DONE;
            OP_SHIFT_DEL:      if (in_re < in_rs) state_d = S_DONE;
            OP_LOOKUP, OP_MERGE, OP_CLEAR_KEY: if (!key_ok) state_d = S_DONE;
            OP_CLEAR_ALL: begin
              valid_d = '0;
              state_d = S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_RD: state_d = S_EV;
      S_EV: begin
        adv = 1'b1;
        case (op_q)
          OP_ADD, OP_REMOVE: begin
            if (!pass_q) begin
              if (!v_cur) nfree_d = nfree_q + CW'(1);
              if (hit && rdata_q.s < rs_q && rdata_q.e > re_q)
                nsplit_d = nsplit_q + CW'(1);
            end else if (hit) begin
              if (rdata_q.s >= rs_q && rdata_q.e <= re_q) begin
                valid_d[idx_q] = 1'b0;
              end else begin
                mem_we = 1'b1;
                if (rdata_q.s < rs_q) begin
                  mem_wdata.e = rs_q;
                  if (rdata_q.e > re_q) begin
                    sp_e_d = rdata_q.e;  sp_v_d = rdata_q.v;
                    adv = 1'b0;  state_d = S_SPLIT;
                  end
                end else begin
                  mem_wdata.s = re_q;
                end
              end
            end
          end
          OP_LOOKUP: begin
            if (match && rdata_q.s <= pos_q && rdata_q.e > pos_q &&
                (!res_found_q || rdata_q.s > w_s_q)) begin
              res_found_d = 1'b1;  res_val_d = rdata_q.v;  w_s_d = rdata_q.s;
            end
          end
          OP_SHIFT_INS: begin
            if (v_cur) begin
              if (rdata_q.s >= pos_q) begin
                mem_we = 1'b1;
                mem_wdata.s = sat_add(rdata_q.s, len_q);
                mem_wdata.e = sat_add(rdata_q.e, len_q);
              end else if (rdata_q.e > pos_q) begin
                mem_we = 1'b1;
                mem_wdata.e = sat_add(rdata_q.e, len_q);
              end
            end
          end
          OP_SHIFT_DEL: begin
            if (v_cur && rdata_q.e > rs_q) begin
              if (rdata_q.s >= re_q) begin
                mem_we = 1'b1;
                mem_wdata.s = rdata_q.s - dlen;  mem_wdata.e = rdata_q.e - dlen;
              end else if (rdata_q.s >= rs_q && rdata_q.e <= re_q) begin
                valid_d[idx_q] = 1'b0;
              end else if (rdata_q.s < rs_q && rdata_q.e > re_q) begin
                mem_we = 1'b1;  mem_wdata.e = rdata_q.e - dlen;
              end else if (rdata_q.s < rs_q) begin
                mem_we = 1'b1;  mem_wdata.e = rs_q;
              end else begin
                mem_we = 1'b1;
                mem_wdata.s = rs_q;  mem_wdata.e = rdata_q.e - dlen;
              end
            end
          end
          OP_MERGE: begin
            if (match && !seen_q[idx_q] && (!cand_q || rdata_q.s < cand_s_q)) begin
              cand_d = 1'b1;  cand_idx_d = idx_q;  cand_s_d = rdata_q.s;
              cand_e_d = rdata_q.e;  cand_v_d = rdata_q.v;
            end
          end
          OP_CLEAR_KEY: if (match) valid_d[idx_q] = 1'b0;
          default: ;
        endcase
      end
      S_SPLIT: begin
        // The tail piece starts at the range end, so the cut walk never hits it.
        mem_we = 1'b1;  mem_addr = free_idx;
        mem_wdata = '{key: key_q, s: re_q, e: sp_e_q, v: sp_v_q};
        valid_d[free_idx] = 1'b1;
        adv = 1'b1;
      end
      S_CHECK: begin
        if ({1'b0, nfree_q} < need) begin
          res_status_d = 1'b1;  state_d = S_DONE;
        end else begin
          pass_d = 1'b1;  idx_d = '0;  state_d = S_RD;
        end
      end
      S_STORE: begin
        mem_we = 1'b1;  mem_addr = free_idx;
        mem_wdata = '{key: key_q, s: rs_q, e: re_q, v: val_q};
        valid_d[free_idx] = 1'b1;
        state_d = S_DONE;
      end
      S_MDEC: begin
        idx_d = '0;  cand_d = 1'b0;  state_d = S_RD;
        if (!have_w_q) begin
          if (!cand_q) begin
            state_d = S_DONE;
          end else begin
            have_w_d = 1'b1;  w_idx_d = cand_idx_q;  w_s_d = cand_s_q;
            w_e_d = cand_e_q;  w_v_d = cand_v_q;  seen_d[cand_idx_q] = 1'b1;
          end
        end else if (!cand_q || cand_s_q > w_e_q) begin
          cand_d = cand_q;  state_d = S_MWB;
        end else begin
          if (cand_e_q > w_e_q) w_e_d = cand_e_q;
          valid_d[cand_idx_q] = 1'b0;  seen_d[cand_idx_q] = 1'b1;
        end
      end
      S_MWB: begin
        // Close the current group, then open the next one at the candidate.
        mem_we = 1'b1;  mem_addr = w_idx_q;
        mem_wdata = '{key: key_q, s: w_s_q, e: w_e_q, v: w_v_q};
        have_w_d = 1'b0;
        state_d = S_MDEC;
        if (!cand_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;  state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (adv) begin
      if (!last) begin
        idx_d = idx_q + IW'(1);  state_d = S_RD;
      end else begin
        case (op_q)
          OP_ADD, OP_REMOVE: begin
            if (!pass_q)              state_d = S_CHECK;
            else if (op_q == OP_ADD)  state_d = S_STORE;
            else                      state_d = S_DONE;
          end
          OP_MERGE: state_d = S_MDEC;
          default:  state_d = S_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seen_q <= seen_d;    op_q <= op_d;       key_q <= key_d;
    rs_q <= rs_d;        re_q <= re_d;       pos_q <= pos_d;
    len_q <= len_d;      val_q <= val_d;     idx_q <= idx_d;
    pass_q <= pass_d;    nsplit_q <= nsplit_d; nfree_q <= nfree_d;
    cand_q <= cand_d;    cand_idx_q <= cand_idx_d; cand_s_q <= cand_s_d;
    cand_e_q <= cand_e_d; cand_v_q <= cand_v_d; have_w_q <= have_w_d;
    w_idx_q <= w_idx_d;  w_s_q <= w_s_d;     w_e_q <= w_e_d;  w_v_q <= w_v_d;
    sp_e_q <= sp_e_d;    sp_v_q <= sp_v_d;
    res_found_q <= res_found_d; res_val_q <= res_val_d;
    res_status_q <= res_status_d;
    if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
      out_found_q  <= res_found_q;
      out_val_q    <= res_found_q ? res_val_q : '0;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.found_value = FieldBits'(out_val_q);
  assign out_o.status      = out_status_q;

endmodule

[rtl/core/kiat_checker.sv]
// ----------------------------------------------------------------------------
// kiat_checker
// Port-level checks on the result channel of the interval table.
// ----------------------------------------------------------------------------
module kiat_checker import kiat_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 found_i,
  input logic [FieldBits-1:0] found_value_i,
  input logic                 status_i
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(found_i) &&
    $stable(found_value_i) && $stable(status_i))
    else $error("result beat changed while stalled");

  // Only lookups find, and only a refused add or remove sets status.
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(found_i && status_i))
    else $error("found and status both set");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> found_value_i == '0)
    else $error("value without a found interval");

  // The table works on one operation at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("new beat taken while busy");

endmodule

bind keyed_interval_attribute_table_top kiat_checker u_kiat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .found_i       (out_o.found),
  .found_value_i (out_o.found_value),
  .status_i      (out_o.status)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives operation beats into the keyed interval attribute table. A
// behavioral copy of the table predicts each result beat, and a checker
// compares every result field with the oldest prediction. Directed tests
// come first, then random phases with sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import kiat_pkg::*;

  localparam int unsigned NSLOT      = 32;
  localparam int unsigned CYCLE_CAP  = 20000000;
  localparam int unsigned DRAIN_WAIT = 200;

  typedef struct {
    op_e         op;
    logic [2:0]  key;
    logic [31:0] rs;
    logic [31:0] re;
    logic [31:0] pos;
    logic [31:0] len;
    logic [31:0] val;
  } table_op_t;

  typedef struct {
    logic        found;
    logic [31:0] fval;
    logic        status;
  } table_res_t;

  logic clk;
  logic rst_n;

  kiat_in_if  in_bus ();
  kiat_out_if out_bus ();

  keyed_interval_attribute_table_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Shadow copy of the slot table.
  bit          sh_valid [NSLOT];
  logic [2:0]  sh_key   [NSLOT];
  logic [31:0] sh_start [NSLOT];
  logic [31:0] sh_end   [NSLOT];
  logic [31:0] sh_val   [NSLOT];
  bit          sh_seen  [NSLOT];

  table_res_t  pending_results [$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned idle_pct;
  int unsigned stall_pct;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int lowest_free();
    for (int i = 0; i < NSLOT; i++) if (!sh_valid[i]) return i;
    return -1;
  endfunction

  function automatic int free_slots();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (!sh_valid[i]) n++;
    return n;
  endfunction

  function automatic bit overlaps(int i, logic [2:0] k, logic [31:0] rs, logic [31:0] re);
    return sh_valid[i] && sh_key[i] == k && sh_start[i] < re && sh_end[i] > rs;
  endfunction

  function automatic int split_count(logic [2:0] k, logic [31:0] rs, logic [31:0] re);
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++)
      if (overlaps(i, k, rs, re) && sh_start[i] < rs && sh_end[i] > re) n++;
    return n;
  endfunction

  function automatic void place(logic [2:0] k, logic [31:0] s, logic [31:0] e,
                                logic [31:0] v);
    int j;
    j = lowest_free();
    if (j < 0) return;
    sh_valid[j] = 1'b1;
    sh_key[j]   = k;
    sh_start[j] = s;
    sh_end[j]   = e;
    sh_val[j]   = v;
  endfunction

  function automatic void carve(logic [2:0] k, logic [31:0] rs, logic [31:0] re);
    for (int i = 0; i < NSLOT; i++) begin
      if (!overlaps(i, k, rs, re)) continue;
      if (sh_start[i] >= rs && sh_end[i] <= re) begin
        sh_valid[i] = 1'b0;
      end else if (sh_start[i] < rs && sh_end[i] > re) begin
        place(k, re, sh_end[i], sh_val[i]);
        sh_end[i] = rs;
      end else if (sh_start[i] < rs) begin
        sh_end[i] = rs;
      end else begin
        sh_start[i] = re;
      end
    end
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int earliest_unseen(logic [2:0] k);
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!sh_valid[i] || sh_key[i] != k || sh_seen[i]) continue;
      if (best < 0 || sh_start[i] < sh_start[best]) best = i;
    end
    return best;
  endfunction

  function automatic void join_key(logic [2:0] k);
    int w, r;
    for (int i = 0; i < NSLOT; i++) sh_seen[i] = 1'b0;
    w = earliest_unseen(k);
    while (w >= 0) begin
      sh_seen[w] = 1'b1;
      forever begin
        r = earliest_unseen(k);
        if (r < 0 || sh_start[r] > sh_end[w]) break;
        if (sh_end[r] > sh_end[w]) sh_end[w] = sh_end[r];
        sh_valid[r] = 1'b0;
      end
      w = r;
    end
  endfunction

  // Applies one operation to the shadow table and returns its result beat.
  function automatic table_res_t apply_op(table_op_t t);
    table_res_t  res;
    int          best;
    logic [31:0] d, s, e;
    res = '{found: 1'b0, fval: 32'd0, status: 1'b0};
    case (t.op)
      OP_ADD: begin
        if (t.re >= t.rs) begin
          if (free_slots() < split_count(t.key, t.rs, t.re) + 1) begin
            res.status = 1'b1;
          end else begin
            carve(t.key, t.rs, t.re);
            place(t.key, t.rs, t.re, t.val);
          end
        end
      end
      OP_REMOVE: begin
        if (t.re >= t.rs) begin
          if (free_slots() < split_count(t.key, t.rs, t.re)) res.status = 1'b1;
          else carve(t.key, t.rs, t.re);
        end
      end
      OP_LOOKUP: begin
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (!sh_valid[i] || sh_key[i] != t.key) continue;
          if (sh_start[i] > t.pos || sh_end[i] <= t.pos) continue;
          if (best < 0 || sh_start[i] > sh_start[best]) best = i;
        end
        if (best >= 0) begin
          res.found = 1'b1;
          res.fval  = sh_val[best];
        end
      end
      OP_SHIFT_INS: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!sh_valid[i]) continue;
          if (sh_start[i] >= t.pos) begin
            sh_start[i] = sat_sum(sh_start[i], t.len);
            sh_end[i]   = sat_sum(sh_end[i], t.len);
          end else if (sh_end[i] > t.pos) begin
            sh_end[i] = sat_sum(sh_end[i], t.len);
          end
        end
      end
      OP_SHIFT_DEL: begin
        if (t.re >= t.rs) begin
          d = t.re - t.rs;
          for (int i = 0; i < NSLOT; i++) begin
            s = sh_start[i];
            e = sh_end[i];
            if (!sh_valid[i] || e <= t.rs) continue;
            if (s >= t.re) begin
              sh_start[i] = s - d;
              sh_end[i]   = e - d;
            end else if (s >= t.rs && e <= t.re) begin
              sh_valid[i] = 1'b0;
            end else if (s < t.rs && e > t.re) begin
              sh_end[i] = e - d;
            end else if (s < t.rs) begin
              sh_end[i] = t.rs;
            end else begin
              sh_start[i] = t.rs;
              sh_end[i]   = e - d;
            end
          end
        end
      end
      OP_MERGE: join_key(t.key);
      OP_CLEAR_KEY: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && sh_key[i] == t.key) sh_valid[i] = 1'b0;
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) sh_valid[i] = 1'b0;
      end
    endcase
    return res;
  endfunction

  // Sends one beat, with a random idle gap first, and predicts its result.
  // Ready only changes at a rising edge, so it is checked at the falling edge.
  task automatic send_op(table_op_t t);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid       = 1'b1;
    in_bus.operation   = t.op;
    in_bus.key         = t.key;
    in_bus.range_start = t.rs;
    in_bus.range_end   = t.re;
    in_bus.position    = t.pos;
    in_bus.length      = t.len;
    in_bus.value       = t.val;
    while (!in_bus.ready) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(apply_op(t));
  endtask

  function automatic table_op_t mk(op_e op, logic [2:0] k, logic [31:0] rs,
                                   logic [31:0] re, logic [31:0] pos = 0,
                                   logic [31:0] len = 0, logic [31:0] val = 0);
    table_op_t t;
    t = '{op: op, key: k, rs: rs, re: re, pos: pos, len: len, val: val};
    return t;
  endfunction

  task automatic test_add_lookup();
    send_op(mk(OP_ADD, 3'd0, 32'd10, 32'd20, 0, 0, 32'hFFFF_FFFF));
    send_op(mk(OP_ADD, 3'd0, 32'd15, 32'd18, 0, 0, 32'h1234_5678));
    send_op(mk(OP_LOOKUP, 3'd0, 0, 0, 32'd16));
    send_op(mk(OP_LOOKUP, 3'd0, 0, 0, 32'd19));
    send_op(mk(OP_LOOKUP, 3'd7, 0, 0, 32'd19));
    // Empty interval is stored but never matches a lookup.
    send_op(mk(OP_ADD, 3'd7, 32'd5, 32'd5, 0, 0, 32'd9));
    send_op(mk(OP_ADD, 3'd7, 32'd9, 32'd3, 0, 0, 32'd1));
    send_op(mk(OP_LOOKUP, 3'd7, 0, 0, 32'd5));
  endtask

  task automatic test_remove_split();
    send_op(mk(OP_ADD, 3'd1, 32'd100, 32'd200, 0, 0, 32'd77));
    send_op(mk(OP_REMOVE, 3'd1, 32'd150, 32'd150));
    send_op(mk(OP_REMOVE, 3'd1, 32'd120, 32'd130));
    send_op(mk(OP_REMOVE, 3'd1, 32'd190, 32'd110));
    send_op(mk(OP_LOOKUP, 3'd1, 0, 0, 32'd160));
    send_op(mk(OP_MERGE, 3'd1, 0, 0));
    send_op(mk(OP_LOOKUP, 3'd1, 0, 0, 32'd125));
  endtask

  task automatic test_shifts();
    send_op(mk(OP_ADD, 3'd2, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0, 0, 32'd5));
    send_op(mk(OP_SHIFT_INS, 3'd0, 0, 0, 32'd12, 32'hFFFF_FFFF));
    send_op(mk(OP_SHIFT_DEL, 3'd0, 32'd0, 32'hFFFF_FFFF));
    send_op(mk(OP_SHIFT_DEL, 3'd0, 32'd50, 32'd40));
    send_op(mk(OP_LOOKUP, 3'd2, 0, 0, 32'd0));
    send_op(mk(OP_CLEAR_KEY, 3'd2, 0, 0));
    send_op(mk(OP_CLEAR_ALL, 3'd0, 0, 0));
  endtask

  // Fills the table with one key, then asks for an add and a split it cannot take.
  task automatic test_table_full();
    for (int i = 0; i < NSLOT; i++)
      send_op(mk(OP_ADD, 3'd4, 32'(i * 10), 32'(i * 10 + 5), 0, 0, 32'(i)));
    send_op(mk(OP_ADD, 3'd5, 32'd1000, 32'd1001, 0, 0, 32'd1));
    send_op(mk(OP_REMOVE, 3'd4, 32'd2, 32'd3));
    send_op(mk(OP_ADD, 3'd4, 32'd0, 32'd5, 0, 0, 32'd99));
    send_op(mk(OP_CLEAR_ALL, 3'd0, 0, 0));
  endtask

  function automatic logic [31:0] rand_offset();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 85) return $urandom_range(300);
    if (pick < 95) return 32'hFFFF_FFFF - $urandom_range(300);
    return $urandom;
  endfunction

  function automatic table_op_t rand_op();
    table_op_t   t;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 34)      t.op = OP_ADD;
    else if (pick < 50) t.op = OP_REMOVE;
    else if (pick < 72) t.op = OP_LOOKUP;
    else if (pick < 79) t.op = OP_SHIFT_INS;
    else if (pick < 86) t.op = OP_SHIFT_DEL;
    else if (pick < 92) t.op = OP_MERGE;
    else if (pick < 97) t.op = OP_CLEAR_KEY;
    else                t.op = OP_CLEAR_ALL;
    t.key = 3'($urandom_range(7));
    t.rs  = rand_offset();
    t.re  = sat_sum(t.rs, $urandom_range(60));
    if ($urandom_range(99) < 5) t.re = $urandom;
    t.pos = rand_offset();
    t.len = ($urandom_range(99) < 90) ? 32'($urandom_range(40)) : 32'($urandom);
    t.val = $urandom;
    return t;
  endfunction

  task automatic test_random_phase(int unsigned idle, int unsigned stall, int unsigned n);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_op(rand_op());
  endtask

  always @(negedge clk) begin
    out_bus.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    table_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat at cycle %0d", cycles);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.found !== want.found || out_bus.found_value !== want.fval ||
            out_bus.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at cycle %0d: found %0b/%0b value %h/%h status %0b/%0b",
                     cycles, want.found, out_bus.found, want.fval, out_bus.found_value,
                     want.status, out_bus.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    mismatches         = 0;
    cycles             = 0;
    idle_pct           = 0;
    stall_pct          = 0;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.operation   = OP_ADD;
    in_bus.key         = '0;
    in_bus.range_start = '0;
    in_bus.range_end   = '0;
    in_bus.position    = '0;
    in_bus.length      = '0;
    in_bus.value       = '0;
    out_bus.ready      = 1'b0;
    for (int i = 0; i < NSLOT; i++) sh_valid[i] = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_add_lookup();
    test_remove_split();
    test_shifts();
    test_table_full();
    test_random_phase(0, 0, 400);
    test_random_phase(53, 0, 400);
    test_random_phase(0, 53, 400);
    test_random_phase(10, 10, 400);

    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
